/* rtl/smp_pkg.sv */
// smp_pkg: shared types and constants for the substring match block.
// Holds the beat structs, the cell control struct and the register index codes.
// No dependencies.
package smp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 5;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 64;
  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned PAT_BYTES = 16;

  localparam logic [BYTE_W-1:0] STRIP_BYTE = 8'hC3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 8'd0,
    REG_PATTERN_HIGH = 8'd1,
    REG_PATTERN_LEN  = 8'd2,
    REG_STRIP_EN     = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              final_byte;
  } in_beat_t;

  typedef struct packed {
    logic               match_found;
    logic [FIELD_W-1:0] match_start;
    logic [FIELD_W-1:0] match_end;
    logic               text_done;
    logic [FIELD_W-1:0] occurrence_total;
    logic               overflow_flag;
  } out_beat_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

endpackage

/* rtl/smp_cell.sv */
// smp_cell: one window cell; holds a kept text byte and its valid bit.
// Compares the byte it takes in against its aligned pattern byte.
// Depends on smp_pkg.
module smp_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  smp_pkg::cell_ctl_t        ctl,
  input  logic [smp_pkg::BYTE_W-1:0] byte_in,
  input  logic                      valid_in,
  input  logic [smp_pkg::BYTE_W-1:0] pat_byte,
  output logic [smp_pkg::BYTE_W-1:0] byte_out,
  output logic                      valid_out,
  output logic                      eq
);

  logic [smp_pkg::BYTE_W-1:0] byte_r;
  logic                       valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clear) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out  = byte_r;
  assign valid_out = valid_r;
  assign eq        = valid_in && (byte_in == pat_byte);

endmodule

/* rtl/smp_match.sv */
// smp_match: chain of window cells and the parallel pattern compare.
// Aligns the pattern to the window and reduces the cell compares to one hit.
// Depends on smp_pkg and smp_cell.
module smp_match #(
  parameter int unsigned MAX_PATTERN = 16
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  smp_pkg::cell_ctl_t                             ctl,
  input  logic [smp_pkg::BYTE_W-1:0]                     new_byte,
  input  logic [smp_pkg::PAT_BYTES*smp_pkg::BYTE_W-1:0]  pat_vec,
  input  logic [smp_pkg::LEN_W-1:0]                      len,
  output logic                                           hit
);

  logic [smp_pkg::BYTE_W-1:0] byte_q  [MAX_PATTERN];
  logic                       valid_q [MAX_PATTERN];
  logic [smp_pkg::BYTE_W-1:0] aligned [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]     eq;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [smp_pkg::LEN_W-1:0] pidx;

    assign pidx       = len - 1'b1 - smp_pkg::LEN_W'(j);
    assign aligned[j] = pat_vec[pidx[3:0]*smp_pkg::BYTE_W +: smp_pkg::BYTE_W];

    if (j == 0) begin : g_head
      smp_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .byte_in   (new_byte),
        .valid_in  (1'b1),
        .pat_byte  (aligned[j]),
        .byte_out  (byte_q[j]),
        .valid_out (valid_q[j]),
        .eq        (eq[j])
      );
    end else begin : g_body
      smp_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .byte_in   (byte_q[j-1]),
        .valid_in  (valid_q[j-1]),
        .pat_byte  (aligned[j]),
        .byte_out  (byte_q[j]),
        .valid_out (valid_q[j]),
        .eq        (eq[j])
      );
    end
  end

  always_comb begin
    hit = (len != '0);
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (smp_pkg::LEN_W'(j) < len) begin
        hit = hit & eq[j];
      end
    end
  end

endmodule

/* rtl/substring_match_positions.sv */
// substring_match_positions: top level of the streaming substring search.
// Holds configuration, position and count state, and the output register.
// Depends on smp_pkg and smp_match.
//
// Takes one text byte per clock and reports each leftmost, non-overlapping
// occurrence of a pattern of up to MAX_PATTERN bytes with its 1-based start
// and end positions in the text after 0xC3 bytes are dropped (when stripping
// is on), plus a closing beat with the running total on the final byte. Every
// byte shifts through a row of window cells that compare against the pattern
// in parallel, so a new byte is taken every cycle and a report it triggers is
// registered in the cycle after the byte is accepted; in_ready falls only
// while a result waits and out_ready is low. Positions and the count stop at
// 2^POSITION_BITS-1 and set overflow_flag. Write configuration only while the
// block is idle; it takes effect on the next byte.
module substring_match_positions #(
  parameter int unsigned MAX_PATTERN   = 16,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  smp_pkg::in_beat_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output smp_pkg::out_beat_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [smp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smp_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int unsigned BLK_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [POSITION_BITS-1:0] POS_LIMIT = {POSITION_BITS{1'b1}};

  logic [smp_pkg::CFG_DAT_W-1:0] pat_low_r;
  logic [smp_pkg::CFG_DAT_W-1:0] pat_high_r;
  logic [smp_pkg::LEN_W-1:0]     len_cfg_r;
  logic                          strip_en_r;

  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] count_r, count_nxt;
  logic [BLK_W-1:0]         blk_r, blk_nxt;
  logic                     sat_r, sat_nxt;

  logic                     out_valid_r;
  smp_pkg::out_beat_t       out_data_r, out_data_nxt;

  logic                     in_accept;
  logic                     keep;
  logic                     hit;
  logic                     found;
  logic                     emit;
  logic [smp_pkg::LEN_W-1:0] len_use;
  logic [POSITION_BITS-1:0] len_ext;
  logic [POSITION_BITS-1:0] start_pos;
  smp_pkg::cell_ctl_t       cell_ctl;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      len_cfg_r  <= smp_pkg::LEN_W'(1);
      strip_en_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        smp_pkg::REG_PATTERN_LOW:  pat_low_r  <= cfg_data;
        smp_pkg::REG_PATTERN_HIGH: pat_high_r <= cfg_data;
        smp_pkg::REG_PATTERN_LEN:  len_cfg_r  <= cfg_data[smp_pkg::LEN_W-1:0];
        smp_pkg::REG_STRIP_EN:     strip_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign len_use = (len_cfg_r > smp_pkg::LEN_W'(MAX_PATTERN)) ?
                   smp_pkg::LEN_W'(MAX_PATTERN) : len_cfg_r;
  assign len_ext = POSITION_BITS'(len_use);

  // handshake
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign keep      = !(strip_en_r && (in_data.text_byte == smp_pkg::STRIP_BYTE));

  assign cell_ctl.shift = in_accept && keep;
  assign cell_ctl.clear = in_accept && in_data.final_byte;

  smp_match #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cell_ctl),
    .new_byte (in_data.text_byte),
    .pat_vec  ({pat_high_r, pat_low_r}),
    .len      (len_use),
    .hit      (hit)
  );

  always_comb begin
    pos_nxt   = pos_r;
    count_nxt = count_r;
    blk_nxt   = blk_r;
    sat_nxt   = sat_r;
    found     = 1'b0;
    if (keep) begin
      if (pos_r != POS_LIMIT) begin
        pos_nxt = pos_r + 1'b1;
      end else begin
        sat_nxt = 1'b1;
      end
      if (blk_r != '0) begin
        blk_nxt = blk_r - 1'b1;
      end else if (hit) begin
        found   = 1'b1;
        blk_nxt = BLK_W'(len_use - 1'b1);
        if (count_r != POS_LIMIT) begin
          count_nxt = count_r + 1'b1;
        end else begin
          sat_nxt = 1'b1;
        end
      end
    end
  end

  assign start_pos = (pos_nxt >= len_ext) ? (pos_nxt - len_ext + 1'b1) : '0;
  assign emit      = found || in_data.final_byte;

  always_comb begin
    out_data_nxt.match_found      = found;
    out_data_nxt.match_start      = found ? smp_pkg::FIELD_W'(start_pos) : '0;
    out_data_nxt.match_end        = found ? smp_pkg::FIELD_W'(pos_nxt) : '0;
    out_data_nxt.text_done        = in_data.final_byte;
    out_data_nxt.occurrence_total = smp_pkg::FIELD_W'(count_nxt);
    out_data_nxt.overflow_flag    = sat_nxt;
  end

  // text state; the final byte clears it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      count_r <= '0;
      blk_r   <= '0;
      sat_r   <= 1'b0;
    end else if (in_accept) begin
      if (in_data.final_byte) begin
        pos_r   <= '0;
        count_r <= '0;
        blk_r   <= '0;
        sat_r   <= 1'b0;
      end else begin
        pos_r   <= pos_nxt;
        count_r <= count_nxt;
        blk_r   <= blk_nxt;
        sat_r   <= sat_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_count_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !sat_r |-> (count_r <= pos_r))
    else $error("match count ran ahead of text position");

  a_blocked_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && found && !in_data.final_byte) |=>
      (blk_r == BLK_W'($past(len_use) - 1'b1)))
    else $error("block counter not loaded after a match");

  a_no_hit_while_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (blk_r != '0) |-> !found)
    else $error("match reported inside a blocked span");

  a_clear_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.final_byte) |=>
      (pos_r == '0 && count_r == '0 && blk_r == '0 && !sat_r))
    else $error("text state not cleared after final byte");
`endif

endmodule

/* tb/smp_checker.sv */
`timescale 1ns / 100ps
// smp_checker: watches the text, report and register channels of the substring search,
// predicts each report beat from its own copy of pattern and text state, and compares.
// Depends on smp_pkg.
module smp_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  smp_pkg::in_beat_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  smp_pkg::out_beat_t            out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [smp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smp_pkg::CFG_DAT_W-1:0] cfg_data,
  output int unsigned                   mismatches,
  output int unsigned                   reports_due
);

  logic [63:0] pat_low, pat_high;
  logic [4:0]  pat_len;
  logic        strip_on;

  logic [7:0]  window [smp_pkg::PAT_BYTES];
  logic [4:0]  fill, blocked;
  logic [15:0] position, hits;
  logic        saturated;

  smp_pkg::out_beat_t expected_reports[$];
  int unsigned fails = 0;
  int unsigned due = 0;

  assign mismatches  = fails;
  assign reports_due = due;

  function automatic void clear_text();
    int k;
    for (k = 0; k < smp_pkg::PAT_BYTES; k++) window[k] = '0;
    fill      = '0;
    blocked   = '0;
    position  = '0;
    hits      = '0;
    saturated = 1'b0;
  endfunction

  function automatic bit scan_text_byte(input smp_pkg::in_beat_t beat,
                                        output smp_pkg::out_beat_t rep);
    logic [127:0] pat;
    logic [4:0]   span;
    bit           found, hit;
    int           k;
    pat   = {pat_high, pat_low};
    span  = (pat_len > 5'd16) ? 5'd16 : pat_len;
    found = 1'b0;
    rep   = '0;
    if (!(strip_on && beat.text_byte == smp_pkg::STRIP_BYTE)) begin
      for (k = smp_pkg::PAT_BYTES - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = beat.text_byte;
      if (fill < 5'd16) fill++;
      if (position != 16'hFFFF) position++;
      else saturated = 1'b1;
      if (blocked != 0) begin
        blocked--;
      end else if (span != 0 && fill >= span) begin
        hit = 1'b1;
        for (k = 0; k < span; k++) begin
          if (window[span-1-k] != pat[8*k +: 8]) hit = 1'b0;
        end
        if (hit) begin
          found             = 1'b1;
          rep.match_found   = 1'b1;
          rep.match_end     = position;
          rep.match_start   = (position >= span) ? position - span + 16'd1 : '0;
          if (hits != 16'hFFFF) hits++;
          else saturated = 1'b1;
          blocked = span - 5'd1;
        end
      end
    end
    rep.text_done        = beat.final_byte;
    rep.occurrence_total = hits;
    rep.overflow_flag    = saturated;
    if (beat.final_byte) clear_text();
    return found || beat.final_byte;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= 100) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    smp_pkg::out_beat_t want, rep;
    if (!rst_n) begin
      pat_low  = '0;
      pat_high = '0;
      pat_len  = 5'd1;
      strip_on = 1'b1;
      clear_text();
      expected_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          smp_pkg::REG_PATTERN_LOW:  pat_low  = cfg_data;
          smp_pkg::REG_PATTERN_HIGH: pat_high = cfg_data;
          smp_pkg::REG_PATTERN_LEN:  pat_len  = cfg_data[4:0];
          smp_pkg::REG_STRIP_EN:     strip_on = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          fails++;
          if (fails <= 100) $error("report beat with nothing expected: %h", out_data);
        end else begin
          want = expected_reports.pop_front();
          check_field("match_found", want.match_found, out_data.match_found);
          check_field("match_start", want.match_start, out_data.match_start);
          check_field("match_end", want.match_end, out_data.match_end);
          check_field("text_done", want.text_done, out_data.text_done);
          check_field("occurrence_total", want.occurrence_total, out_data.occurrence_total);
          check_field("overflow_flag", want.overflow_flag, out_data.overflow_flag);
        end
      end
      if (in_valid && in_ready) begin
        if (scan_text_byte(in_data, rep)) expected_reports.push_back(rep);
      end
    end
    due <= expected_reports.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// tb: top of the substring search testbench; drives texts and register writes,
// stalls the report side at random, and gives the verdict. Depends on smp_pkg,
// smp_checker and substring_match_positions.
module tb;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned RANDOM_BEATS = 380;
  localparam int unsigned CALM_BEATS   = 40;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid, in_ready;
  smp_pkg::in_beat_t  in_data;
  logic               out_valid, out_ready;
  smp_pkg::out_beat_t out_data;
  logic               cfg_valid, cfg_ready;
  logic [smp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [smp_pkg::CFG_DAT_W-1:0] cfg_data;
  int unsigned        mismatches, reports_due;

  logic [7:0]  pat_bytes [smp_pkg::PAT_BYTES];
  logic [4:0]  pat_len;
  logic        strip_on;
  bit          calm;
  int unsigned sent;

  substring_match_positions i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  smp_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .reports_due (reports_due)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 24);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(19))
      0, 1, 2, 3, 4: return 8'h41;
      5, 6, 7, 8:    return 8'h42;
      9, 10:         return 8'h00;
      11, 12:        return 8'hFF;
      13:            return smp_pkg::STRIP_BYTE;
      default:       return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic last);
    smp_pkg::in_beat_t beat;
    beat.text_byte  = b;
    beat.final_byte = last;
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input smp_pkg::cfg_reg_t idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic configure(input logic [4:0] len, input logic strip);
    logic [63:0] low_word, high_word;
    int k;
    for (k = 0; k < 8; k++) begin
      low_word[8*k +: 8]  = pat_bytes[k];
      high_word[8*k +: 8] = pat_bytes[k+8];
    end
    pat_len  = len;
    strip_on = strip;
    write_reg(smp_pkg::REG_PATTERN_LOW, low_word);
    write_reg(smp_pkg::REG_PATTERN_HIGH, high_word);
    write_reg(smp_pkg::REG_PATTERN_LEN, {59'd0, len});
    write_reg(smp_pkg::REG_STRIP_EN, {63'd0, strip});
  endtask

  // mostly whole pattern copies, some cut short, with stray and stripped bytes
  task automatic send_text(input int unsigned span);
    logic [7:0]  txt[$];
    int unsigned k, use_len, cut;
    use_len = (pat_len > 16) ? 16 : ((pat_len == 0) ? 3 : pat_len);
    while (txt.size() < span) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          for (k = 0; k < use_len; k++) begin
            if (strip_on && $urandom_range(15) == 0) txt.push_back(smp_pkg::STRIP_BYTE);
            txt.push_back(pat_bytes[k]);
          end
        end
        5: begin
          cut = $urandom_range(use_len - 1);
          for (k = 0; k < cut; k++) txt.push_back(pat_bytes[k]);
          txt.push_back(pick_byte());
        end
        6: txt.push_back(smp_pkg::STRIP_BYTE);
        default: txt.push_back(pick_byte());
      endcase
    end
    for (k = 0; k < txt.size(); k++) send_beat(txt[k], k == txt.size() - 1);
    sent += txt.size();
  endtask

  initial begin
    int unsigned k, phase_end;
    logic [4:0]  len;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    calm      = 1'b0;
    sent      = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: pattern is a single zero byte, stripping on
    send_beat(8'h00, 1'b0);
    send_beat(smp_pkg::STRIP_BYTE, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(smp_pkg::STRIP_BYTE, 1'b1);
    settle();

    // oversized length clamps to a full 16 byte pattern
    for (k = 0; k < smp_pkg::PAT_BYTES; k++)
      pat_bytes[k] = (k == 0) ? 8'h00 : ((k == 15) ? 8'hFF : 8'(8'h30 + k));
    configure(5'd20, 1'b1);
    for (k = 0; k < smp_pkg::PAT_BYTES; k++) begin
      if (k == 8) send_beat(smp_pkg::STRIP_BYTE, 1'b0);
      send_beat(pat_bytes[k], k == 15);
    end
    settle();

    // zero length never matches
    for (k = 0; k < smp_pkg::PAT_BYTES; k++) pat_bytes[k] = 8'hFF;
    configure(5'd0, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'hFF, 1'b1);
    settle();

    // run one text with no idling on either side: a match on every kept beat
    for (k = 0; k < smp_pkg::PAT_BYTES; k++) pat_bytes[k] = pick_byte();
    pat_bytes[0] = 8'h41;
    configure(5'd1, 1'b1);
    calm = 1'b1;
    for (k = 0; k < CALM_BEATS; k++)
      send_beat((k % 13 == 7) ? smp_pkg::STRIP_BYTE : 8'h41, k == CALM_BEATS - 1);
    calm = 1'b0;
    settle();

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      for (k = 0; k < smp_pkg::PAT_BYTES; k++) pat_bytes[k] = pick_byte();
      case ($urandom_range(9))
        0:       len = 5'd1;
        1:       len = 5'd16;
        2:       len = 5'($urandom_range(31, 17));
        3:       len = 5'd0;
        default: len = 5'($urandom_range(6, 2));
      endcase
      configure(len, 1'($urandom_range(1)));
      phase_end = sent + 50;
      while (sent < phase_end)
        send_text(($urandom_range(3) == 0) ? $urandom_range(3, 1) : $urandom_range(40, 4));
      settle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && reports_due == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* substring_match_positions.f */
rtl/smp_pkg.sv
rtl/smp_cell.sv
rtl/smp_match.sv
rtl/substring_match_positions.sv
tb/smp_checker.sv
tb/tb.sv
